// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit free-list allocator: payload structs, status codes, FSM states.
// No dependencies.
package ffa_pkg;

    localparam int ADDR_W = 48;
    localparam int LEN_W  = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NULLFREE = 2'd3
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  request_size;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  block_size;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,       // issue read of entry idx
        S_WAIT,     // read latency
        S_CHK,      // evaluate entry
        S_PREV,     // free: read previous entry
        S_PREVW,
        S_DECIDE,   // free: merge decision
        S_SHL_RD,   // shift table down (remove)
        S_SHL_WR,
        S_SHR_RD,   // shift table up (insert)
        S_SHR_WR,
        S_DONE
    } fsm_t;

endpackage

// ----- rtl/ffa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/first_fit_free_list_allocator.sv -----
// First-fit free-list allocator top level: sequencer around one extent-table RAM.
// Depends on ffa_pkg and ffa_ram.
//
// The block holds an address-sorted table of free extents (start, length) in a RAM of
// MAX_EXTENTS entries and serves one transaction at a time. An allocate scans entries in
// order until one fits (per entry: read, RAM latency, compare), then updates or removes
// it; a free scans for its insertion point, reads the previous neighbor, merges or
// inserts. Removal and insertion move the tail of the table one entry at a time (read,
// RAM latency, write). Transaction time thus grows with the number of entries scanned
// and moved; the longest is a free inserted at the front of a nearly full table, and the
// single RAM port pair sets it. A configuration write rebuilds the table (only entry zero
// and the count change; entries past the count are never read), and reset writes entry
// zero while it is held. The result waits in an output register; ready is high only when
// idle with no result pending.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int MAX_EXTENTS     = 32,
    parameter int HEADER_BYTES    = 8,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    input  logic              m_ready,
    output logic              m_valid,
    output rsp_t              m_data
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = ADDR_W + LEN_W;

    // configuration and table control
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  bytes_reg;
    logic [CW-1:0]     count_reg, count_next;
    fsm_t              state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    req_t              req_reg;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [LEN_W:0]    len_reg, len_next;   // one spare bit for merge checks
    logic [33:0]       need_reg;
    logic [EW-1:0]     cur_reg, cur_next;   // entry at idx
    logic              mn_reg, mn_next;
    rsp_t              rsp_reg, rsp_next;
    logic              mvalid_reg, mvalid_next;

    // RAM
    logic              we;
    logic [IW-1:0]     waddr, raddr;
    logic [EW-1:0]     wdata, rdata;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_tab (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata), .raddr (raddr), .rdata (rdata)
    );

    logic [ADDR_W-1:0] r_start;
    logic [LEN_W-1:0]  r_len;
    assign r_start = rdata[EW-1:LEN_W];
    assign r_len   = rdata[LEN_W-1:0];

    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = rsp_reg;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= CW'(1);
            mvalid_reg <= 1'b0;
            base_reg   <= '0;
            bytes_reg  <= LEN_W'(1048576);
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_HEAP_BASE) base_reg <= cfg_wdata;
                else bytes_reg <= cfg_wdata[LEN_W-1:0];
                count_reg <= CW'(1);
            end
        end
        idx_reg <= idx_next;
        blk_reg <= blk_next;
        len_reg <= len_next;
        cur_reg <= cur_next;
        mn_reg  <= mn_next;
        rsp_reg <= rsp_next;
        if (s_valid && s_ready) begin
            req_reg  <= s_data;
            need_reg <= (34'(s_data.request_size) + 34'(HEADER_BYTES) + 34'd15) & ~34'd15;
        end
    end

    logic [ADDR_W-1:0] c_start;
    logic [LEN_W-1:0]  c_len;
    assign c_start = cur_reg[EW-1:LEN_W];
    assign c_len   = cur_reg[LEN_W-1:0];

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        blk_next    = blk_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        mn_next     = mn_reg;
        rsp_next    = rsp_reg;
        mvalid_next = mvalid_reg && !m_ready;
        we    = 1'b0;
        waddr = idx_reg[IW-1:0];
        wdata = cur_reg;
        raddr = idx_reg[IW-1:0];
        if (cfg_we) begin
            // rebuild: entry zero from the updated registers
            we    = 1'b1;
            waddr = '0;
            wdata = (cfg_index == CFG_HEAP_BASE) ? {cfg_wdata, bytes_reg}
                                                 : {base_reg, cfg_wdata[LEN_W-1:0]};
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    idx_next = '0;
                    blk_next = s_data.address - ADDR_W'(HEADER_BYTES);
                    len_next = {1'b0, s_data.block_size};
                    rsp_next.result_address = '0;
                    if (s_data.cmd == CMD_FREE && s_data.address == '0) begin
                        rsp_next.status = ST_NULLFREE;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (idx_reg >= count_reg) begin
                    if (req_reg.cmd == CMD_ALLOC) begin
                        rsp_next.status = ST_OOM;
                        state_next = S_DONE;
                    end else begin
                        mn_next = 1'b0;
                        state_next = S_PREV;
                    end
                end else begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                cur_next   = rdata;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (req_reg.cmd == CMD_ALLOC) begin
                    if (34'(c_len) >= need_reg) begin
                        rsp_next.status = ST_OK;
                        rsp_next.result_address = c_start + ADDR_W'(HEADER_BYTES);
                        if (34'(c_len) > need_reg + 34'(MIN_SPLIT_BYTES)) begin
                            we    = 1'b1;
                            wdata = {c_start + ADDR_W'(need_reg),
                                     c_len - need_reg[LEN_W-1:0]};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SHL_RD;
                        end
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                end else begin
                    if (c_start < blk_reg) begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end else begin
                        mn_next = (blk_reg + ADDR_W'(len_reg[LEN_W-1:0]) == c_start) &&
                                  ((LEN_W+1)'(c_len) + len_reg <= (LEN_W+1)'({LEN_W{1'b1}}));
                        if ((blk_reg + ADDR_W'(len_reg[LEN_W-1:0]) == c_start) &&
                            ((LEN_W+1)'(c_len) + len_reg <= (LEN_W+1)'({LEN_W{1'b1}})))
                            len_next = len_reg + (LEN_W+1)'(c_len);
                        state_next = S_PREV;
                    end
                end
            end
            S_PREV: begin
                raddr = IW'(idx_reg - CW'(1));
                state_next = S_PREVW;
            end
            S_PREVW: begin
                raddr = IW'(idx_reg - CW'(1));
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                rsp_next.status = ST_OK;
                if (idx_reg != '0 && (r_start + ADDR_W'(r_len) == blk_reg) &&
                    ((LEN_W+1)'(r_len) + len_reg <= (LEN_W+1)'({LEN_W{1'b1}}))) begin
                    // merge into previous
                    we    = 1'b1;
                    waddr = IW'(idx_reg - CW'(1));
                    wdata = {r_start, r_len + len_reg[LEN_W-1:0]};
                    state_next = mn_reg ? S_SHL_RD : S_DONE;
                end else if (mn_reg) begin
                    we    = 1'b1;
                    wdata = {blk_reg, len_reg[LEN_W-1:0]};
                    state_next = S_DONE;
                end else if (count_reg >= CW'(MAX_EXTENTS)) begin
                    rsp_next.status = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    // insert: shift entries [idx, count) up by one, from the top
                    cur_next   = {blk_reg, len_reg[LEN_W-1:0]};
                    mn_next    = 1'b0;
                    blk_next   = ADDR_W'(idx_reg);  // remember insert point
                    idx_next   = count_reg;
                    state_next = S_SHR_RD;
                end
            end
            S_SHL_RD: begin
                // move entry idx+1 to idx while idx+1 < count
                if (idx_reg + CW'(1) >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    raddr = IW'(idx_reg + CW'(1));
                    state_next = S_SHL_WR;
                end
            end
            S_SHL_WR: begin
                raddr = IW'(idx_reg + CW'(1));
                if (mn_reg) begin
                    we   = 1'b1;
                    wdata = rdata;
                    idx_next = idx_reg + CW'(1);
                    mn_next  = 1'b0;
                    state_next = S_SHL_RD;
                end else begin
                    mn_next = 1'b1;   // wait for read data
                end
            end
            S_SHR_RD: begin
                if (idx_reg == CW'(blk_reg)) begin
                    we    = 1'b1;
                    wdata = cur_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end else begin
                    raddr = IW'(idx_reg - CW'(1));
                    state_next = S_SHR_WR;
                end
            end
            S_SHR_WR: begin
                raddr = IW'(idx_reg - CW'(1));
                if (mn_reg) begin
                    we    = 1'b1;
                    wdata = rdata;
                    idx_next = idx_reg - CW'(1);
                    mn_next  = 1'b0;
                    state_next = S_SHR_RD;
                end else begin
                    mn_next = 1'b1;
                end
            end
            S_DONE: begin
                mvalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // while reset is held, entry zero takes the reset region
        if (!aresetn) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {ADDR_W'(0), LEN_W'(1048576)};
        end
    end

endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checker for the first-fit allocator, with its bind to the top level.
// Depends on ffa_pkg.
module ffa_checker
    import ffa_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // no new transaction while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accepted while result pending");

    // a failed allocate or a failed free returns address zero
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.result_address == '0)
        else $error("nonzero address on failure");

    // accepted transaction does not produce an output the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
    .m_valid (m_valid), .m_ready (m_ready), .m_data (m_data)
);

// ----- dv/first_fit_free_list_allocator_tb.sv -----
// Self-checking testbench for the first-fit free-list allocator.
// Depends on ffa_pkg and the first_fit_free_list_allocator RTL.
module first_fit_free_list_allocator_tb;
    import ffa_pkg::*;

    localparam int NUM_EXTENTS = 32;
    localparam int HDR_BYTES   = 8;
    localparam int SPLIT_BYTES = 16;
    localparam longint CYCLE_LIMIT = 1500000;

    // Allocation predictor plus expected-response store
    class alloc_scoreboard;
        logic [ADDR_W-1:0] ext_start [NUM_EXTENTS];
        logic [LEN_W-1:0]  ext_len   [NUM_EXTENTS];
        int                ext_count;
        logic [ADDR_W-1:0] base_addr;
        logic [LEN_W-1:0]  region_len;
        rsp_t              pending_rsp [$];
        int                errors;

        function void rebuild();
            for (int i = 0; i < NUM_EXTENTS; i++) begin
                ext_start[i] = '0;
                ext_len[i] = '0;
            end
            ext_start[0] = base_addr;
            ext_len[0] = region_len;
            ext_count = 1;
        endfunction

        function void reset_state();
            base_addr = '0;
            region_len = 32'd1048576;
            errors = 0;
            rebuild();
        endfunction

        function void write_cfg(logic idx, logic [ADDR_W-1:0] val);
            if (idx == CFG_HEAP_BASE) base_addr = val;
            else region_len = val[LEN_W-1:0];
            rebuild();
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i + 1 < ext_count; i++) begin
                ext_start[i] = ext_start[i+1];
                ext_len[i] = ext_len[i+1];
            end
            ext_count--;
        endfunction

        // Note an accepted request and compute its response
        function void note_request(req_t rq);
            rsp_t r;
            logic [33:0] need;
            logic [ADDR_W-1:0] blk, s;
            logic [33:0] len;
            int pos;
            bit mn, mp, found;
            r.result_address = '0;
            r.status = ST_OK;
            found = 0;
            if (rq.cmd == CMD_ALLOC) begin
                need = ({2'b0, rq.request_size} + HDR_BYTES + 15) & ~34'd15;
                for (int i = 0; i < ext_count && !found; i++) begin
                    if ({2'b0, ext_len[i]} >= need) begin
                        found = 1;
                        s = ext_start[i];
                        if ({2'b0, ext_len[i]} > need + SPLIT_BYTES) begin
                            ext_start[i] = s + need[31:0];
                            ext_len[i] = ext_len[i] - need[31:0];
                        end else begin
                            remove_at(i);
                        end
                        r.result_address = s + HDR_BYTES;
                    end
                end
                if (!found) r.status = ST_OOM;
            end else if (rq.address == '0) begin
                r.status = ST_NULLFREE;
            end else begin
                blk = rq.address - HDR_BYTES;
                len = {2'b0, rq.block_size};
                pos = 0;
                while (pos < ext_count && ext_start[pos] < blk) pos++;
                mn = pos < ext_count && (blk + len[31:0]) == ext_start[pos]
                     && len + ext_len[pos] <= 34'hFFFFFFFF;
                if (mn) len = len + ext_len[pos];
                mp = pos > 0 && (ext_start[pos-1] + ext_len[pos-1]) == blk
                     && ext_len[pos-1] + len <= 34'hFFFFFFFF;
                if (mp && mn) begin
                    ext_len[pos-1] = ext_len[pos-1] + len[31:0];
                    remove_at(pos);
                end else if (mp) begin
                    ext_len[pos-1] = ext_len[pos-1] + len[31:0];
                end else if (mn) begin
                    ext_start[pos] = blk;
                    ext_len[pos] = len[31:0];
                end else if (ext_count >= NUM_EXTENTS) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = ext_count; i > pos; i--) begin
                        ext_start[i] = ext_start[i-1];
                        ext_len[i] = ext_len[i-1];
                    end
                    ext_start[pos] = blk;
                    ext_len[pos] = len[31:0];
                    ext_count++;
                end
            end
            pending_rsp.push_back(r);
        endfunction

        // Compare a response with the oldest expectation
        function void check_response(rsp_t got);
            rsp_t exp_rsp;
            if (pending_rsp.size() == 0) begin
                $error("unexpected response addr=%h status=%0d",
                       got.result_address, got.status);
                errors++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.result_address !== exp_rsp.result_address) begin
                $error("result_address expected %h actual %h",
                       exp_rsp.result_address, got.result_address);
                errors++;
            end
            if (got.status !== exp_rsp.status) begin
                $error("status expected %0d actual %0d", exp_rsp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              cfg_we = 0;
    logic              cfg_index = 0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_valid = 0;
    logic              s_ready;
    req_t              s_data = '0;
    logic              m_ready = 0;
    logic              m_valid;
    rsp_t              m_data;

    alloc_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 0;
    longint cycle_cnt = 0;
    logic [ADDR_W-1:0] live_ptr [$];
    logic [LEN_W-1:0]  live_len [$];

    first_fit_free_list_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[first_fit_free_list_allocator] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, optional long hold-off; check each transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_response(m_data);
        if (!aresetn || hold_recv) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up after acceptance until the next item or an idle cycle replaces it
    task automatic send_req(req_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(rq);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge aclk);
        repeat (5 * NUM_EXTENTS + 20) @(posedge aclk);
    endtask

    task automatic cfg_write(logic idx, logic [ADDR_W-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_cfg(idx, val);
        live_ptr.delete();
        live_len.delete();
    endtask

    function automatic req_t mk_alloc(logic [LEN_W-1:0] sz);
        req_t rq;
        rq = '0;
        rq.cmd = CMD_ALLOC;
        rq.request_size = sz;
        rq.address = ADDR_W'({$urandom, $urandom});
        rq.block_size = $urandom;
        return rq;
    endfunction

    function automatic req_t mk_free(logic [ADDR_W-1:0] p, logic [LEN_W-1:0] bs);
        req_t rq;
        rq.cmd = CMD_FREE;
        rq.request_size = $urandom;
        rq.address = p;
        rq.block_size = bs;
        return rq;
    endfunction

    // One random transaction: mostly well-formed alloc/free of live blocks
    task automatic random_item();
        int k, sel;
        logic [LEN_W-1:0] sz;
        rsp_t r;
        sel = $urandom_range(99);
        if (sel < 45 || live_ptr.size() == 0) begin
            sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
            send_req(mk_alloc(sz));
            r = sb.pending_rsp[$];
            if (r.status == ST_OK) begin
                live_ptr.push_back(r.result_address);
                live_len.push_back((sz + HDR_BYTES + 15) & ~32'd15);
            end
        end else if (sel < 88) begin
            k = $urandom_range(live_ptr.size() - 1);
            send_req(mk_free(live_ptr[k], live_len[k]));
            live_ptr.delete(k);
            live_len.delete(k);
        end else if (sel < 93) begin
            send_req(mk_free('0, $urandom));
        end else begin
            send_req(mk_free(ADDR_W'({$urandom, $urandom}), $urandom));
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, null free, out of memory, merges, wrap, table full
        send_req(mk_alloc(32'd0));
        send_req(mk_alloc(32'd8));
        send_req(mk_alloc(32'hFFFFFFFF));
        send_req(mk_alloc(32'd1048560));
        send_req(mk_free('0, 32'hFFFFFFFF));
        send_req(mk_free(48'h8, 32'd16));
        send_req(mk_free(48'h18, 32'd32));
        send_req(mk_free(48'h0, 32'd0));
        send_req(mk_free(48'hFFFFFFFFFFFF, 32'hFFFFFFFF));
        cfg_write(CFG_HEAP_BASE, 48'hFFFFFFFFFF00);
        cfg_write(CFG_HEAP_BYTES, ADDR_W'(32'hFFFFFFFF));
        send_req(mk_alloc(32'd100));
        send_req(mk_alloc(32'hFFFFFFE0));
        send_req(mk_free(48'h4, 32'd1));
        cfg_write(CFG_HEAP_BYTES, ADDR_W'(32'd0));
        send_req(mk_alloc(32'd0));
        cfg_write(CFG_HEAP_BASE, 48'h1000);
        cfg_write(CFG_HEAP_BYTES, ADDR_W'(32'd4096));
        for (int i = 0; i < 34; i++) send_req(mk_free(48'h100000 + i * 64, 32'd16));
        send_req(mk_alloc(32'd5000));

        // Random phases with differing idle patterns and settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 25 : 0;
            cfg_write(CFG_HEAP_BASE,
                      (ph == 1) ? ADDR_W'({$urandom, $urandom}) : 48'h40000);
            cfg_write(CFG_HEAP_BYTES, ADDR_W'((ph == 2) ? 32'd2048 : 32'd65536));
            for (int n = 0; n < 280; n++) begin
                if (ph == 2 && n == 100) begin
                    hold_recv = 1;
                    fork
                        begin
                            repeat (400) @(posedge aclk);
                            hold_recv = 0;
                        end
                    join_none
                end
                random_item();
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("[first_fit_free_list_allocator] OK");
        end else begin
            $display("[first_fit_free_list_allocator] ERROR");
        end
        $finish;
    end
endmodule
